// ----- sv/phq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the presence hysteresis qualifier: item codes, register map,
// state and config structs, counter helpers. No dependencies.
package phq_pkg;

    localparam int COUNT_WIDTH = 16;               // run counters, 4..32
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int IDX_WIDTH   = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;

    typedef enum logic [1:0] {
        FUNC_SAMPLE    = 2'd0,
        FUNC_REJECT    = 2'd1,
        FUNC_FORCE     = 2'd2,
        FUNC_LINK_LOST = 2'd3
    } phq_func_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_DETECT = 2'd1,
        EV_LOST   = 2'd2
    } phq_event_t;

    localparam logic [IDX_WIDTH-1:0] REG_ENTRY    = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_HYST     = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_ENTER    = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_LEAVE    = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_IDENT    = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_REJ_LIM  = 3'd5;

    localparam cfg_word_t ENTRY_RST   = 16'd100;
    localparam cfg_word_t HYST_RST    = 16'd20;
    localparam cfg_word_t ENTER_RST   = 16'd3;
    localparam cfg_word_t LEAVE_RST   = 16'd5;
    localparam cfg_word_t IDENT_RST   = 16'd200;
    localparam cfg_word_t REJ_LIM_RST = 16'd50;

    typedef struct packed {
        cfg_word_t entry_cm;
        cfg_word_t hyst_cm;
        cfg_word_t enter_cnt;
        cfg_word_t leave_cnt;
        cfg_word_t ident_cnt;
        cfg_word_t rej_limit;
    } phq_cfg_t;

    typedef struct packed {
        logic      presence_flag;
        count_t    near_run;
        count_t    far_run;
        cfg_word_t repeat_value;
        count_t    repeat_run;
        logic      stuck_flag;
        count_t    reject_run;
        cfg_word_t latest_distance;
    } phq_state_t;

    typedef struct packed {
        logic       present;
        phq_event_t presence_event;
        logic       sensor_stuck;
        logic       reject_alarm;
        cfg_word_t  last_distance_cm;
    } phq_result_t;

    function automatic count_t sat_inc(input count_t v);
        return (&v) ? v : v + count_t'(1);
    endfunction

    // counter >= 16-bit threshold, both zero-extended to the wider width
    function automatic logic cnt_ge(input count_t c, input cfg_word_t t);
        logic [CMP_WIDTH-1:0] ce;
        logic [CMP_WIDTH-1:0] te;
        ce = CMP_WIDTH'(c);
        te = CMP_WIDTH'(t);
        return ce >= te;
    endfunction

endpackage

// ----- sv/phq_update.sv -----
`timescale 1ns / 1ps
// Next-state and result logic for one word of the presence qualifier.
// Depends on phq_pkg.
module phq_update import phq_pkg::*; (
    input  phq_cfg_t    cfg,
    input  phq_state_t  cur,
    input  phq_func_t   func,
    input  cfg_word_t   distance_cm,
    input  logic        forced_state,
    output phq_state_t  nxt,
    output phq_result_t res
);

    logic              is_near;
    logic              is_far;
    logic [CFG_WIDTH:0] exit_th;
    phq_event_t        ev;

    assign exit_th = {1'b0, cfg.entry_cm} + {1'b0, cfg.hyst_cm};
    assign is_near = (distance_cm <= cfg.entry_cm);
    assign is_far  = ({1'b0, distance_cm} > exit_th);

    always_comb begin
        nxt = cur;
        ev  = EV_NONE;
        case (func)
            FUNC_SAMPLE: begin
                if (distance_cm != '0) begin
                    nxt.reject_run      = '0;
                    nxt.latest_distance = distance_cm;
                    if (distance_cm == cur.repeat_value) begin
                        nxt.repeat_run = sat_inc(cur.repeat_run);
                        if (cfg.ident_cnt != '0 && cnt_ge(nxt.repeat_run, cfg.ident_cnt)) begin
                            nxt.stuck_flag = 1'b1;
                        end
                    end else begin
                        nxt.repeat_value = distance_cm;
                        nxt.repeat_run   = count_t'(1);
                        nxt.stuck_flag   = 1'b0;
                    end
                    if (is_near) begin
                        nxt.far_run  = '0;
                        nxt.near_run = sat_inc(cur.near_run);
                        if (!cur.presence_flag && cnt_ge(nxt.near_run, cfg.enter_cnt)) begin
                            nxt.presence_flag = 1'b1;
                            ev = EV_DETECT;
                        end
                    end else if (is_far) begin
                        nxt.near_run = '0;
                        nxt.far_run  = sat_inc(cur.far_run);
                        if (cur.presence_flag && cnt_ge(nxt.far_run, cfg.leave_cnt)) begin
                            nxt.presence_flag = 1'b0;
                            ev = EV_LOST;
                        end
                    end
                end
            end
            FUNC_REJECT: begin
                nxt.reject_run = sat_inc(cur.reject_run);
            end
            FUNC_FORCE: begin
                if (forced_state != cur.presence_flag) begin
                    nxt.presence_flag = forced_state;
                    nxt.near_run      = '0;
                    nxt.far_run       = '0;
                    ev = forced_state ? EV_DETECT : EV_LOST;
                end
            end
            default: begin
                // link lost: drop presence, counters kept
                if (cur.presence_flag) begin
                    nxt.presence_flag = 1'b0;
                    ev = EV_LOST;
                end
            end
        endcase
    end

    always_comb begin
        res.present          = nxt.presence_flag;
        res.presence_event   = ev;
        res.sensor_stuck     = nxt.stuck_flag;
        res.reject_alarm     = (nxt.reject_run != '0) && cnt_ge(nxt.reject_run, cfg.rej_limit);
        res.last_distance_cm = nxt.latest_distance;
    end

endmodule

// ----- sv/presence_hysteresis_qualifier.sv -----
`timescale 1ns / 1ps
// Presence hysteresis qualifier, top level. The result word is registered
// and valid in the cycle after its input is accepted. One word per cycle
// while m_ready is high; the single result register refills as it drains.
// Reset (aresetn low, synchronous) clears all run state and the output
// valid, and loads the register defaults. Depends on phq_pkg, phq_update.
module presence_hysteresis_qualifier import phq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [15:0]          s_distance_cm,
    input  logic                 s_forced_state,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_present,
    output logic [1:0]           m_presence_event,
    output logic                 m_sensor_stuck,
    output logic                 m_reject_alarm,
    output logic [15:0]          m_last_distance_cm
);

    phq_cfg_t    cfg_reg;
    phq_state_t  state_reg;
    phq_state_t  state_next;
    phq_result_t res_reg;
    phq_result_t res_next;
    logic        m_valid_reg;
    logic        s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    phq_update u_update (
        .cfg          (cfg_reg),
        .cur          (state_reg),
        .func         (phq_func_t'(s_func)),
        .distance_cm  (s_distance_cm),
        .forced_state (s_forced_state),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.entry_cm  <= ENTRY_RST;
            cfg_reg.hyst_cm   <= HYST_RST;
            cfg_reg.enter_cnt <= ENTER_RST;
            cfg_reg.leave_cnt <= LEAVE_RST;
            cfg_reg.ident_cnt <= IDENT_RST;
            cfg_reg.rej_limit <= REJ_LIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENTRY:   cfg_reg.entry_cm  <= cfg_wdata;
                REG_HYST:    cfg_reg.hyst_cm   <= cfg_wdata;
                REG_ENTER:   cfg_reg.enter_cnt <= cfg_wdata;
                REG_LEAVE:   cfg_reg.leave_cnt <= cfg_wdata;
                REG_IDENT:   cfg_reg.ident_cnt <= cfg_wdata;
                REG_REJ_LIM: cfg_reg.rej_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_present          = res_reg.present;
    assign m_presence_event   = res_reg.presence_event;
    assign m_sensor_stuck     = res_reg.sensor_stuck;
    assign m_reject_alarm     = res_reg.reject_alarm;
    assign m_last_distance_cm = res_reg.last_distance_cm;

    // shown flag tracks the stored state whenever the output is valid
    a_present_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.present == state_reg.presence_flag))
        else $error("present output disagrees with presence state");

    a_detect_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.presence_event == EV_DETECT) |-> res_reg.present)
        else $error("detect event without presence");

    a_lost_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.presence_event == EV_LOST) |-> !res_reg.present)
        else $error("lost event with presence still set");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(state_reg))
        else $error("state changed without an accepted word");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted word did not produce a result");

endmodule

// ----- verif/phq_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for presence_hysteresis_qualifier: tracks register writes, predicts
// each result word from the accepted input words and compares. Uses phq_pkg.
module phq_checker import phq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [15:0]          s_distance_cm,
    input  logic                 s_forced_state,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_present,
    input  logic [1:0]           m_presence_event,
    input  logic                 m_sensor_stuck,
    input  logic                 m_reject_alarm,
    input  logic [15:0]          m_last_distance_cm,
    output int                   fail_count,
    output int                   words_pending,
    output int                   words_checked,
    output int                   events_seen,
    output int                   stuck_seen,
    output int                   alarm_seen
);

    typedef struct {
        logic        present;
        count_t      near_run;
        count_t      far_run;
        logic [15:0] repeat_dist;
        count_t      repeat_run;
        logic        stuck;
        count_t      reject_run;
        logic [15:0] last_dist;
    } qual_state_t;

    cfg_word_t   regs_q [0:5];
    qual_state_t st;
    phq_result_t expected_q [$];

    initial begin
        fail_count    = 0;
        words_pending = 0;
        words_checked = 0;
        events_seen   = 0;
        stuck_seen    = 0;
        alarm_seen    = 0;
    end

    function automatic count_t bump(input count_t v);
        return (~v == '0) ? v : v + 1'b1;
    endfunction

    // zero-extended compare, counter width may differ from register width
    function automatic logic run_reached(input count_t run, input cfg_word_t limit);
        return longint'(run) >= longint'(limit);
    endfunction

    function automatic phq_result_t qualify_word(input phq_func_t f, input logic [15:0] dist_cm,
                                                 input logic forced);
        phq_result_t r;
        logic [16:0] far_above;
        r = '0;
        r.presence_event = EV_NONE;
        far_above = {1'b0, regs_q[REG_ENTRY]} + regs_q[REG_HYST];
        case (f)
            FUNC_SAMPLE: begin
                if (dist_cm != '0) begin
                    st.reject_run = '0;
                    st.last_dist  = dist_cm;
                    if (dist_cm == st.repeat_dist) begin
                        st.repeat_run = bump(st.repeat_run);
                        if (regs_q[REG_IDENT] != '0 && run_reached(st.repeat_run, regs_q[REG_IDENT]))
                            st.stuck = 1'b1;
                    end else begin
                        st.repeat_dist = dist_cm;
                        st.repeat_run  = count_t'(1);
                        st.stuck       = 1'b0;
                    end
                    if (dist_cm <= regs_q[REG_ENTRY]) begin
                        st.far_run  = '0;
                        st.near_run = bump(st.near_run);
                        if (!st.present && run_reached(st.near_run, regs_q[REG_ENTER])) begin
                            st.present       = 1'b1;
                            r.presence_event = EV_DETECT;
                        end
                    end else if ({1'b0, dist_cm} > far_above) begin
                        st.near_run = '0;
                        st.far_run  = bump(st.far_run);
                        if (st.present && run_reached(st.far_run, regs_q[REG_LEAVE])) begin
                            st.present       = 1'b0;
                            r.presence_event = EV_LOST;
                        end
                    end
                end
            end
            FUNC_REJECT: st.reject_run = bump(st.reject_run);
            FUNC_FORCE: begin
                if (forced != st.present) begin
                    st.present       = forced;
                    st.near_run      = '0;
                    st.far_run       = '0;
                    r.presence_event = forced ? EV_DETECT : EV_LOST;
                end
            end
            default: begin
                if (st.present) begin
                    st.present       = 1'b0;
                    r.presence_event = EV_LOST;
                end
            end
        endcase
        r.present          = st.present;
        r.sensor_stuck     = st.stuck;
        r.reject_alarm     = (st.reject_run != '0) && run_reached(st.reject_run, regs_q[REG_REJ_LIM]);
        r.last_distance_cm = st.last_dist;
        return r;
    endfunction

    always @(posedge aclk) begin
        phq_result_t got;
        phq_result_t want;
        if (!aresetn) begin
            regs_q[REG_ENTRY]   = ENTRY_RST;
            regs_q[REG_HYST]    = HYST_RST;
            regs_q[REG_ENTER]   = ENTER_RST;
            regs_q[REG_LEAVE]   = LEAVE_RST;
            regs_q[REG_IDENT]   = IDENT_RST;
            regs_q[REG_REJ_LIM] = REJ_LIM_RST;
            st = '{1'b0, '0, '0, '0, '0, 1'b0, '0, '0};
            expected_q.delete();
        end else begin
            if (cfg_wr_en && cfg_index <= REG_REJ_LIM)
                regs_q[cfg_index] = cfg_wdata;

            if (m_valid && m_ready) begin
                got.present          = m_present;
                got.presence_event   = phq_event_t'(m_presence_event);
                got.sensor_stuck     = m_sensor_stuck;
                got.reject_alarm     = m_reject_alarm;
                got.last_distance_cm = m_last_distance_cm;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word: present=%0d event=%0d stuck=%0d alarm=%0d dist=%0d",
                                 $time, got.present, got.presence_event, got.sensor_stuck,
                                 got.reject_alarm, got.last_distance_cm);
                end else begin
                    want = expected_q.pop_front();
                    if (got.present !== want.present ||
                        got.presence_event !== want.presence_event ||
                        got.sensor_stuck !== want.sensor_stuck ||
                        got.reject_alarm !== want.reject_alarm ||
                        got.last_distance_cm !== want.last_distance_cm) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: word %0d exp present=%0d event=%0d stuck=%0d alarm=%0d dist=%0d",
                                     $time, words_checked, want.present, want.presence_event,
                                     want.sensor_stuck, want.reject_alarm, want.last_distance_cm,
                                     "\n%0t: word %0d got present=%0d event=%0d stuck=%0d alarm=%0d dist=%0d",
                                     $time, words_checked, got.present, got.presence_event,
                                     got.sensor_stuck, got.reject_alarm, got.last_distance_cm);
                    end
                    words_checked++;
                    if (want.presence_event != EV_NONE) events_seen++;
                    if (want.sensor_stuck) stuck_seen++;
                    if (want.reject_alarm) alarm_seen++;
                end
            end

            if (s_valid && s_ready)
                expected_q.push_back(qualify_word(phq_func_t'(s_func), s_distance_cm,
                                                  s_forced_state));
        end
        words_pending = expected_q.size();
    end

endmodule

// ----- verif/tb_presence_hysteresis_qualifier.sv -----
`timescale 1ns / 1ps
// Testbench top for presence_hysteresis_qualifier: clock, reset, register writes,
// directed and random sensor words, receiver backpressure. Uses phq_pkg, phq_checker.
module tb_presence_hysteresis_qualifier;
    import phq_pkg::*;

    typedef enum int {ZONE_NEAR, ZONE_FAR, ZONE_DEAD} zone_t;

    localparam logic [IDX_WIDTH-1:0] REG_NONE = '1;   // unmapped index
    localparam int CHUNK_WORDS = 150;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0] cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_func;
    logic [15:0]          s_distance_cm;
    logic                 s_forced_state;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_present;
    logic [1:0]           m_presence_event;
    logic                 m_sensor_stuck;
    logic                 m_reject_alarm;
    logic [15:0]          m_last_distance_cm;

    int fail_count;
    int words_pending;
    int words_checked;
    int events_seen;
    int stuck_seen;
    int alarm_seen;

    int          send_idle_pct = 9;
    int          recv_idle_pct = 46;
    int          hold_off      = 0;
    int          words_sent    = 0;
    int          settings_used = 0;
    int unsigned cur_entry     = ENTRY_RST;
    int unsigned cur_hyst      = HYST_RST;
    zone_t       zone          = ZONE_NEAR;

    presence_hysteresis_qualifier i_dut (.*);

    phq_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, or a long hold-off when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_word(input phq_func_t f, input logic [15:0] d, input logic fs);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= f;
        s_distance_cm  <= d;
        s_forced_state <= fs;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_pending != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [IDX_WIDTH-1:0] idx, input cfg_word_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic write_settings(input cfg_word_t entry, input cfg_word_t hyst,
                                  input cfg_word_t enter, input cfg_word_t leave,
                                  input cfg_word_t ident, input cfg_word_t rej_lim);
        put_reg(REG_ENTRY, entry);
        put_reg(REG_HYST, hyst);
        put_reg(REG_ENTER, enter);
        put_reg(REG_LEAVE, leave);
        put_reg(REG_IDENT, ident);
        put_reg(REG_REJ_LIM, rej_lim);
        put_reg(REG_NONE, cfg_word_t'($urandom));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_entry = entry;
        cur_hyst  = hyst;
        settings_used++;
    endtask

    task automatic random_settings();
        write_settings(cfg_word_t'($urandom_range(1500, 1)), cfg_word_t'($urandom_range(300)),
                       cfg_word_t'($urandom_range(6)), cfg_word_t'($urandom_range(6)),
                       ($urandom_range(3) == 0) ? '0 : cfg_word_t'($urandom_range(6, 2)),
                       cfg_word_t'($urandom_range(5)));
    endtask

    // distance in the requested zone, sometimes right on a threshold edge
    function automatic logic [15:0] pick_distance(input zone_t z);
        int unsigned exit_cm;
        int unsigned v;
        exit_cm = cur_entry + cur_hyst;
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0:       v = cur_entry;
                1:       v = cur_entry + 1;
                2:       v = exit_cm;
                default: v = exit_cm + 1;
            endcase
        end else if (z == ZONE_NEAR && cur_entry >= 1) begin
            v = $urandom_range(cur_entry, 1);
        end else if (z == ZONE_FAR && exit_cm < 65535) begin
            v = $urandom_range(65535, exit_cm + 1);
        end else if (z == ZONE_DEAD && cur_hyst != 0 && cur_entry < 65535) begin
            v = $urandom_range((exit_cm > 65535) ? 65535 : exit_cm, cur_entry + 1);
        end else begin
            v = $urandom_range(65535, 1);
        end
        if (v == 0 || v > 65535)
            v = $urandom_range(65535, 1);
        return v[15:0];
    endfunction

    // mostly runs of samples in one zone, plus reject bursts, forces and link drops
    task automatic random_chunk(input int hold_at, input int pause_at);
        int k;
        int len;
        int roll;
        logic [15:0] d;
        k = 0;
        while (k < CHUNK_WORDS) begin
            if (hold_at >= 0 && k >= hold_at) begin
                hold_off = 80;
                hold_at  = -1;
            end
            if (pause_at >= 0 && k >= pause_at) begin
                drain();
                pause_at = -1;
            end
            roll = $urandom_range(99);
            if (roll < 8) begin
                len = $urandom_range(6, 1);
                repeat (len) send_word(FUNC_REJECT, 16'($urandom), 1'($urandom));
                k += len;
            end else if (roll < 14) begin
                send_word(FUNC_FORCE, 16'($urandom), 1'($urandom));
                k++;
            end else if (roll < 18) begin
                send_word(FUNC_LINK_LOST, 16'($urandom), 1'($urandom));
                k++;
            end else if (roll < 21) begin
                send_word(FUNC_SAMPLE, '0, 1'($urandom));
                k++;
            end else begin
                if ($urandom_range(99) < 12)
                    zone = zone_t'($urandom_range(2));
                d   = pick_distance(zone);
                len = ($urandom_range(99) < 6) ? $urandom_range(8, 2) : 1;
                repeat (len) send_word(FUNC_SAMPLE, d, 1'($urandom));
                k += len;
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_ENTRY;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_func         = FUNC_SAMPLE;
        s_distance_cm  = '0;
        s_forced_state = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: entry 100, exit above 120, enter 3, leave 5
        send_word(FUNC_SAMPLE, 16'd0, 1'b0);         // ignored
        send_word(FUNC_REJECT, 16'd0, 1'b0);
        send_word(FUNC_SAMPLE, 16'd0, 1'b1);         // must not clear reject run
        send_word(FUNC_SAMPLE, 16'd100, 1'b0);
        send_word(FUNC_SAMPLE, 16'd100, 1'b0);
        send_word(FUNC_FORCE, 16'd0, 1'b0);          // same value, runs kept
        send_word(FUNC_SAMPLE, 16'd100, 1'b0);       // detect
        send_word(FUNC_FORCE, 16'hffff, 1'b1);
        send_word(FUNC_SAMPLE, 16'd120, 1'b0);       // dead zone edge
        send_word(FUNC_SAMPLE, 16'd121, 1'b0);
        send_word(FUNC_SAMPLE, 16'd500, 1'b0);
        send_word(FUNC_SAMPLE, 16'hffff, 1'b0);
        send_word(FUNC_SAMPLE, 16'd121, 1'b0);
        send_word(FUNC_SAMPLE, 16'd121, 1'b0);       // lost
        send_word(FUNC_FORCE, 16'd0, 1'b1);
        send_word(FUNC_FORCE, 16'd0, 1'b0);
        send_word(FUNC_FORCE, 16'd0, 1'b1);
        send_word(FUNC_LINK_LOST, 16'd0, 1'b0);
        send_word(FUNC_LINK_LOST, 16'hffff, 1'b1);
        send_word(FUNC_SAMPLE, 16'd1, 1'b0);
        drain();
        write_settings(16'd100, 16'd20, 16'd0, 16'd0, 16'd2, 16'd1);
        send_word(FUNC_SAMPLE, 16'd7, 1'b0);
        send_word(FUNC_SAMPLE, 16'd7, 1'b0);         // stuck
        send_word(FUNC_REJECT, 16'd7, 1'b0);         // alarm at limit 1
        send_word(FUNC_SAMPLE, 16'hffff, 1'b0);
        send_word(FUNC_SAMPLE, 16'd9, 1'b0);
        send_word(FUNC_SAMPLE, 16'd9, 1'b0);
        drain();
        write_settings(16'd100, 16'd20, 16'd0, 16'd0, 16'd0, 16'd1);
        send_word(FUNC_SAMPLE, 16'd9, 1'b0);         // alert off, flag stays
        send_word(FUNC_SAMPLE, 16'd8, 1'b0);
        drain();

        random_settings();
        random_chunk(-1, -1);
        drain();
        write_settings('1, '1, '1, '1, '1, '1);
        random_chunk(-1, -1);

        drain();
        random_settings();
        @(posedge aclk);
        send_idle_pct = 46;
        recv_idle_pct = 9;
        random_chunk(-1, -1);
        drain();
        write_settings('0, '0, '0, '0, '0, '0);
        random_chunk(-1, -1);

        drain();
        random_settings();
        @(posedge aclk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_chunk(40, -1);
        drain();
        random_settings();
        random_chunk(-1, 75);
        drain();
        random_settings();
        random_chunk(-1, -1);

        drain();
        repeat (4) @(posedge aclk);
        $display("Sent %0d sensor words over %0d register settings and three idle mixes.",
                 words_sent, settings_used);
        $display("Checked %0d result words: %0d presence events, %0d stuck, %0d alarm.",
                 words_checked, events_seen, stuck_seen, alarm_seen);
        if (fail_count == 0 && words_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
